@@ design/detl_pkg.sv @@
package detl_pkg;

    // One input word: a directory entry's type code, size and raw bytes 28..31.
    typedef struct packed {
        logic [15:0] type_code;
        logic [31:0] sector_count;
        logic [7:0]  aux_byte_a;
        logic [7:0]  aux_byte_b;
        logic [7:0]  aux_byte_c;
        logic [7:0]  aux_byte_d;
    } t_in_word;

    // One output word: the class number and the decoded length in bytes.
    typedef struct packed {
        logic [4:0]  type_class;
        logic [39:0] length_bytes;
    } t_out_word;

    // Length formula selected by the type code.
    typedef enum logic [2:0] {
        FM_SECTORS,
        FM_NYBBLES,
        FM_WORDS8,
        FM_WORDS8P1,
        FM_WORDP1,
        FM_RECORDS
    } t_formula;

    // File type classes in directory order; unknown codes give zero.
    typedef enum logic [4:0] {
        CLS_UNKNOWN,
        CLS_TEXT,
        CLS_DLEX,
        CLS_SDATA,
        CLS_DAT71,
        CLS_BIN71,
        CLS_LEX71,
        CLS_KEY71,
        CLS_BAS71,
        CLS_FTH71,
        CLS_ROM71,
        CLS_GRA71,
        CLS_ADR71,
        CLS_SYM71,
        CLS_WAXM41,
        CLS_XM41,
        CLS_ALL41,
        CLS_KEY41,
        CLS_STAT41,
        CLS_XDM41,
        CLS_PGM41,
        CLS_TXT75,
        CLS_APP75,
        CLS_DAT75,
        CLS_LEX75,
        CLS_WKS75,
        CLS_BAS75,
        CLS_ROM75
    } t_class;

    // Result of the type code lookup, handed from the classifier to the pipeline.
    typedef struct packed {
        t_class   type_class;
        t_formula formula;
    } t_decode;

    localparam logic [4:0] CLASS_MAX = 5'(CLS_ROM75);

endpackage

@@ design/detl_classify.sv @@
module detl_classify (
    input  logic [15:0]      i_type_code,
    output detl_pkg::t_decode o_decode
);
    import detl_pkg::*;

    // Several codes share a class; each class has exactly one formula.
    always_comb begin
        case (i_type_code) inside
            16'h0001, 16'hE0D1: o_decode = '{CLS_TEXT, FM_SECTORS};
            16'h00FF: o_decode = '{CLS_DLEX, FM_NYBBLES};
            16'hE0D0: o_decode = '{CLS_SDATA, FM_WORDS8};
            16'hE0F0, 16'hE0F1: o_decode = '{CLS_DAT71, FM_RECORDS};
            [16'hE204:16'hE207]: o_decode = '{CLS_BIN71, FM_NYBBLES};
            [16'hE208:16'hE20B]: o_decode = '{CLS_LEX71, FM_NYBBLES};
            16'hE20C, 16'hE20D: o_decode = '{CLS_KEY71, FM_NYBBLES};
            [16'hE214:16'hE217]: o_decode = '{CLS_BAS71, FM_NYBBLES};
            [16'hE218:16'hE21B]: o_decode = '{CLS_FTH71, FM_SECTORS};
            16'hE21C: o_decode = '{CLS_ROM71, FM_NYBBLES};
            16'hE222: o_decode = '{CLS_GRA71, FM_NYBBLES};
            16'hE224: o_decode = '{CLS_ADR71, FM_NYBBLES};
            16'hE22E: o_decode = '{CLS_SYM71, FM_NYBBLES};
            16'hE020: o_decode = '{CLS_WAXM41, FM_WORDS8P1};
            16'hE030: o_decode = '{CLS_XM41, FM_WORDS8P1};
            16'hE040: o_decode = '{CLS_ALL41, FM_WORDS8P1};
            16'hE050: o_decode = '{CLS_KEY41, FM_WORDS8P1};
            16'hE060: o_decode = '{CLS_STAT41, FM_WORDS8P1};
            16'hE070: o_decode = '{CLS_XDM41, FM_WORDS8P1};
            16'hE080: o_decode = '{CLS_PGM41, FM_WORDP1};
            16'hE052: o_decode = '{CLS_TXT75, FM_SECTORS};
            16'hE053: o_decode = '{CLS_APP75, FM_SECTORS};
            16'hE058: o_decode = '{CLS_DAT75, FM_SECTORS};
            16'hE089: o_decode = '{CLS_LEX75, FM_SECTORS};
            16'hE08A: o_decode = '{CLS_WKS75, FM_SECTORS};
            16'hE0FE, 16'hE088: o_decode = '{CLS_BAS75, FM_SECTORS};
            16'hE08B: o_decode = '{CLS_ROM75, FM_SECTORS};
            default: o_decode = '{CLS_UNKNOWN, FM_SECTORS};
        endcase
    end

endmodule

@@ design/directory_entry_type_length_decoder_core.sv @@
// Directory entry type and length decoder, three register stages.
// Throughput: one word per cycle; a stalled output fills bubbles first, then
// holds the whole pipeline, losing and repeating nothing.
// Reset (synchronous, active low) clears the stage valid bits only; the
// data registers are left as they are.
module directory_entry_type_length_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  detl_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output detl_pkg::t_out_word o_out_word
);
    import detl_pkg::*;

    // Stage one holds the registered input word together with its class and
    // formula. Stage two holds the record product and the length from the
    // other formulas. Stage three is the output register.
    logic      r_v1, r_v2, r_v3;
    t_in_word  r1_word;
    t_decode   r1_dec;
    t_decode   n1_dec;
    t_class    r2_class;
    t_formula  r2_formula;
    logic [31:0] r2_prod;
    logic [39:0] r2_alt;
    logic [31:0] n2_prod;
    logic [39:0] n2_alt;
    t_out_word r_out;
    t_out_word n_out;

    // A stage may take a new word when it is empty or its word moves on.
    // The readiness chain lets bubbles collapse while the output is stalled.
    logic ready1, ready2, ready3;

    assign ready3     = !r_v3 || !i_out_stall;
    assign ready2     = !r_v2 || ready3;
    assign ready1     = !r_v1 || ready2;
    assign o_in_stall = !ready1;

    detl_classify u_classify (
        .i_type_code (i_in_word.type_code),
        .o_decode    (n1_dec)
    );

    // Stage two arithmetic. The nybble count is little-endian over three
    // bytes and is rounded up when halved; the word count is big-endian.
    logic [15:0] word_be;
    logic [24:0] nyb_plus1;
    logic [16:0] word_plus1;

    assign word_be    = {r1_word.aux_byte_a, r1_word.aux_byte_b};
    assign nyb_plus1  = {1'b0, r1_word.aux_byte_c, r1_word.aux_byte_b, r1_word.aux_byte_a}
                        + 25'd1;
    assign word_plus1 = {1'b0, word_be} + 17'd1;

    // The record count and record length are both little-endian 16-bit values.
    assign n2_prod = 32'({r1_word.aux_byte_b, r1_word.aux_byte_a})
                   * 32'({r1_word.aux_byte_d, r1_word.aux_byte_c});

    always_comb begin
        case (r1_dec.formula)
            FM_NYBBLES:  n2_alt = {16'd0, nyb_plus1[24:1]};
            FM_WORDS8:   n2_alt = {21'd0, word_be, 3'b000};
            FM_WORDS8P1: n2_alt = {21'd0, word_be, 3'b001};
            FM_WORDP1:   n2_alt = {23'd0, word_plus1};
            default:     n2_alt = {r1_word.sector_count, 8'd0};
        endcase
    end

    // Stage three picks the product for record files and the other length
    // for everything else.
    always_comb begin
        n_out.type_class = 5'(r2_class);
        if (r2_formula == FM_RECORDS) begin
            n_out.length_bytes = {8'd0, r2_prod};
        end else begin
            n_out.length_bytes = r2_alt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_in_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_in_valid) begin
            r1_word <= i_in_word;
            r1_dec  <= n1_dec;
        end
        if (ready2 && r_v1) begin
            r2_class   <= r1_dec.type_class;
            r2_formula <= r1_dec.formula;
            r2_prod    <= n2_prod;
            r2_alt     <= n2_alt;
        end
        if (ready3 && r_v2) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_word  = r_out;

endmodule

@@ design/detl_checker.sv @@
module detl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input detl_pkg::t_out_word o_out_word
);
    import detl_pkg::*;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A word that meets no output stall passes through the pipeline to the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted word did not arrive after three cycles");

    // A stalled output word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

    // Unknown codes use the sector formula, so the low byte is always zero.
    a_unknown_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.type_class == 5'(CLS_UNKNOWN))
            |-> (o_out_word.length_bytes[7:0] == 8'd0))
        else $error("unknown class with length not a whole sector");

    // The class number never goes past the last known class.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.type_class <= CLASS_MAX))
        else $error("class number out of range");

endmodule

bind directory_entry_type_length_decoder_core detl_checker u_detl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

@@ verif/tb_directory_entry_type_length_decoder_core.sv @@
`timescale 1ns / 100ps

module tb_directory_entry_type_length_decoder_core;
    import detl_pkg::*;

    // Random entries after the directed ones, the point in the stream of accepted input
    // words where the sender pauses for a full drain, and the word counts where both sides stop idling.
    localparam int RANDOM_ENTRIES = 1600;
    localparam int DRAIN_AT       = 400;
    localparam int QUIET_FIRST    = 700;
    localparam int QUIET_LAST     = 1000;
    localparam int IDLE_PERCENT   = 21;
    // The tail after the last answer, in which a stray output word would still be caught.
    localparam int TAIL_CYCLES    = 10;
    localparam int QUIET_LIMIT    = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_KNOWN      = 43;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Every type code that the decoder knows. Random entries mostly draw from this list,
    // so that every alias of every class is reached many times over.
    logic [15:0] known_codes [0:NUM_KNOWN-1] = '{
        16'h0001, 16'hE0D1, 16'h00FF, 16'hE0D0, 16'hE0F0, 16'hE0F1,
        16'hE204, 16'hE205, 16'hE206, 16'hE207, 16'hE208, 16'hE209, 16'hE20A, 16'hE20B,
        16'hE20C, 16'hE20D, 16'hE214, 16'hE215, 16'hE216, 16'hE217, 16'hE218, 16'hE219,
        16'hE21A, 16'hE21B, 16'hE21C, 16'hE222, 16'hE224, 16'hE22E,
        16'hE020, 16'hE030, 16'hE040, 16'hE050, 16'hE060, 16'hE070, 16'hE080,
        16'hE052, 16'hE053, 16'hE058, 16'hE089, 16'hE08A, 16'hE0FE, 16'hE088, 16'hE08B
    };

    t_in_word  pending_entries [$];
    t_out_word expected_words [$];
    int        entries_sent = 0;
    int        results_checked = 0;
    int        unknown_codes = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;
    bit [27:0] classes_seen = '0;

    directory_entry_type_length_decoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Expected class and length of one directory entry. The type code picks both the
    // class and the length formula; each code belongs to one class only.
    function automatic t_out_word decode_entry(input t_in_word entry);
        t_class      cls;
        t_formula    formula;
        logic [15:0] word_be;
        logic [23:0] nybbles;
        t_out_word   result;
        word_be = {entry.aux_byte_a, entry.aux_byte_b};
        nybbles = {entry.aux_byte_c, entry.aux_byte_b, entry.aux_byte_a};
        formula = FM_SECTORS;
        case (entry.type_code)
            16'h0001, 16'hE0D1: cls = CLS_TEXT;
            16'h00FF: begin cls = CLS_DLEX; formula = FM_NYBBLES; end
            16'hE0D0: begin cls = CLS_SDATA; formula = FM_WORDS8; end
            16'hE0F0, 16'hE0F1: begin cls = CLS_DAT71; formula = FM_RECORDS; end
            16'hE204, 16'hE205, 16'hE206, 16'hE207: begin
                cls = CLS_BIN71; formula = FM_NYBBLES;
            end
            16'hE208, 16'hE209, 16'hE20A, 16'hE20B: begin
                cls = CLS_LEX71; formula = FM_NYBBLES;
            end
            16'hE20C, 16'hE20D: begin cls = CLS_KEY71; formula = FM_NYBBLES; end
            16'hE214, 16'hE215, 16'hE216, 16'hE217: begin
                cls = CLS_BAS71; formula = FM_NYBBLES;
            end
            16'hE218, 16'hE219, 16'hE21A, 16'hE21B: cls = CLS_FTH71;
            16'hE21C: begin cls = CLS_ROM71; formula = FM_NYBBLES; end
            16'hE222: begin cls = CLS_GRA71; formula = FM_NYBBLES; end
            16'hE224: begin cls = CLS_ADR71; formula = FM_NYBBLES; end
            16'hE22E: begin cls = CLS_SYM71; formula = FM_NYBBLES; end
            16'hE020: begin cls = CLS_WAXM41; formula = FM_WORDS8P1; end
            16'hE030: begin cls = CLS_XM41; formula = FM_WORDS8P1; end
            16'hE040: begin cls = CLS_ALL41; formula = FM_WORDS8P1; end
            16'hE050: begin cls = CLS_KEY41; formula = FM_WORDS8P1; end
            16'hE060: begin cls = CLS_STAT41; formula = FM_WORDS8P1; end
            16'hE070: begin cls = CLS_XDM41; formula = FM_WORDS8P1; end
            16'hE080: begin cls = CLS_PGM41; formula = FM_WORDP1; end
            16'hE052: cls = CLS_TXT75;
            16'hE053: cls = CLS_APP75;
            16'hE058: cls = CLS_DAT75;
            16'hE089: cls = CLS_LEX75;
            16'hE08A: cls = CLS_WKS75;
            16'hE0FE, 16'hE088: cls = CLS_BAS75;
            16'hE08B: cls = CLS_ROM75;
            default: cls = CLS_UNKNOWN;
        endcase
        case (formula)
            FM_NYBBLES:  result.length_bytes = (40'(nybbles) + 40'd1) >> 1;
            FM_WORDS8:   result.length_bytes = 40'(word_be) << 3;
            FM_WORDS8P1: result.length_bytes = (40'(word_be) << 3) + 40'd1;
            FM_WORDP1:   result.length_bytes = 40'(word_be) + 40'd1;
            FM_RECORDS:  result.length_bytes =
                40'({entry.aux_byte_b, entry.aux_byte_a}) *
                40'({entry.aux_byte_d, entry.aux_byte_c});
            default:     result.length_bytes = {entry.sector_count, 8'h00};
        endcase
        result.type_class = cls;
        return result;
    endfunction

    // Bytes lean towards their extremes so that the largest products and sums turn up often.
    function automatic logic [7:0] random_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return 8'h00;
        if (pick < 20) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic t_in_word random_entry();
        t_in_word entry;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            entry.type_code = known_codes[$urandom_range(NUM_KNOWN - 1)];
        end else if (pick < 85) begin
            // One bit away from a known code: the near misses a loose compare would let in.
            entry.type_code = known_codes[$urandom_range(NUM_KNOWN - 1)] ^
                (16'h0001 << $urandom_range(15));
        end else begin
            entry.type_code = 16'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 10) entry.sector_count = 32'h0;
        else if (pick < 20) entry.sector_count = 32'hFFFF_FFFF;
        else entry.sector_count = $urandom;
        entry.aux_byte_a = random_byte();
        entry.aux_byte_b = random_byte();
        entry.aux_byte_c = random_byte();
        entry.aux_byte_d = random_byte();
        return entry;
    endfunction

    task automatic queue_entry(input logic [15:0] code, input logic [31:0] sectors,
                               input logic [7:0] a, input logic [7:0] b,
                               input logic [7:0] c, input logic [7:0] d);
        pending_entries.push_back('{code, sectors, a, b, c, d});
    endtask

    task automatic report_mismatch(input string what, input t_out_word want,
                                   input t_out_word got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected class %0d length 0x%010h, got class %0d length 0x%010h",
                     $realtime, what, want.type_class, want.length_bytes,
                     got.type_class, got.length_bytes);
        end
    endtask

    // Input driver. A word that is offered stays on the bus until it is taken; only then
    // does the driver decide, at random, whether to offer the next one or to idle. The
    // expectation for a word is queued at the very edge at which the block takes it.
    always @(posedge i_clk) begin : drive_inputs
        logic holding;
        logic quiet;
        logic draining;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_words.push_back(decode_entry(i_in_word));
                entries_sent++;
                holding = 1'b0;
            end
            if (!holding) begin
                quiet = entries_sent >= QUIET_FIRST && entries_sent < QUIET_LAST;
                // Once, part way through, the sender waits until the pipeline is empty.
                draining = entries_sent == DRAIN_AT && expected_words.size() != 0;
                if (pending_entries.size() != 0 && !draining &&
                    (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
                    i_in_word  <= pending_entries.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each word taken from the block is compared with the oldest
    // expectation, class and length separately; the stall for the next cycle is then drawn.
    always @(posedge i_clk) begin : check_outputs
        t_out_word want;
        logic      quiet;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("output word with nothing expected", '0, o_out_word);
            end else begin
                want = expected_words.pop_front();
                if (o_out_word.type_class !== want.type_class ||
                    o_out_word.length_bytes !== want.length_bytes) begin
                    report_mismatch("output word mismatch", want, o_out_word);
                end
                classes_seen[want.type_class] = 1'b1;
                if (want.type_class == CLS_UNKNOWN) unknown_codes++;
            end
            results_checked++;
        end
        quiet = results_checked >= QUIET_FIRST && results_checked < QUIET_LAST;
        i_out_stall <= !quiet && $urandom_range(99) < IDLE_PERCENT;
    end

    // Cycles in which neither side moves a word; a hung handshake ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles without a word moving.", QUIET_LIMIT);
        $display("tb_directory_entry_type_length_decoder_core failed");
        $finish;
    end

    initial begin : run_test
        t_in_word entry;
        // Directed entries: each length formula at its extremes, the rounding of odd and
        // even nybble counts, aux bytes that must be ignored, and codes outside the table.
        queue_entry(16'h0001, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(16'hE0D1, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(16'h0000, 32'hFFFF_FFFF, 8'h12, 8'h34, 8'h56, 8'h78);
        queue_entry(16'hFFFF, 32'h0000_0001, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(16'h00FF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        queue_entry(16'hE204, 32'h0000_0000, 8'h02, 8'h00, 8'h00, 8'hFF);
        queue_entry(16'hE208, 32'h0000_0000, 8'h01, 8'h00, 8'h00, 8'h00);
        queue_entry(16'hE21C, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'hFF);
        queue_entry(16'hE214, 32'h0000_0000, 8'h12, 8'h34, 8'h56, 8'h78);
        queue_entry(16'hE0D0, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(16'hE0D0, 32'hFFFF_FFFF, 8'h00, 8'h01, 8'h00, 8'h00);
        queue_entry(16'hE020, 32'h0000_0000, 8'hFF, 8'hFF, 8'h00, 8'h00);
        queue_entry(16'hE070, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
        queue_entry(16'hE080, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(16'hE080, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_entry(16'hE0F0, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(16'hE0F1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        queue_entry(16'hE0F0, 32'h0000_0000, 8'h34, 8'h12, 8'h78, 8'h56);
        queue_entry(16'hE218, 32'h1234_5678, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_entry(16'hE08B, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_entry(16'hE0FE, 32'h8000_0000, 8'h55, 8'hAA, 8'h55, 8'hAA);
        queue_entry(16'hE088, 32'h7FFF_FFFF, 8'hAA, 8'h55, 8'hAA, 8'h55);
        queue_entry(16'hE052, 32'h0000_0001, 8'hFF, 8'h00, 8'hFF, 8'h00);
        for (int n = 0; n < RANDOM_ENTRIES; n++) begin
            entry = random_entry();
            pending_entries.push_back(entry);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let the driver empty its queue, then wait for the last answers and a short tail
        // in which any stray output word would still be caught.
        while (pending_entries.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        error_count += expected_words.size();
        $display("Decoded %0d directory entries, %0d of them with codes outside the table,",
                 results_checked, unknown_codes);
        $display("reaching %0d of the 28 class numbers with %0d errors.",
                 $countones(classes_seen), error_count);
        if (error_count == 0) begin
            $display("tb_directory_entry_type_length_decoder_core passed");
        end else begin
            $display("tb_directory_entry_type_length_decoder_core failed");
        end
        $finish;
    end

endmodule

@@ directory_entry_type_length_decoder_core.f @@
design/detl_pkg.sv
design/detl_classify.sv
design/directory_entry_type_length_decoder_core.sv
design/detl_checker.sv
verif/tb_directory_entry_type_length_decoder_core.sv
